// ===== hw/rtl/lpl_pkg.sv =====
// lpl_pkg: shared types and constants of the lookahead peak limiter
// no dependencies; used by every module of the block by scoped names
package lpl_pkg;

  localparam int GAIN_FRAC = 24;
  localparam int GAIN_W    = 25;
  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 8;
  localparam int QUOT_W    = 24;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'h1000000;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 8'd1;

  localparam logic [REG_W-1:0] THRESHOLD_RST = 24'd8388600;
  localparam logic [REG_W-1:0] RELEASE_RST   = 24'd4368;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WORK,
    ST_GAIN,
    ST_SCALE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== hw/rtl/lpl_front.sv =====
// lpl_front: input side, two-entry queue of samples with their magnitudes
// depends on lpl_pkg; feeds lpl_back
module lpl_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  lpl_pkg::back_status_t         status,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic [SAMPLE_BITS-1:0]        q_mag
);

  logic signed [SAMPLE_BITS-1:0] sample_q [2];
  logic [SAMPLE_BITS-1:0]        mag_q [2];
  logic                          wptr;
  logic                          rptr;
  logic [1:0]                    count;
  logic                          accept;
  logic                          take;
  logic [SAMPLE_BITS-1:0]        mag_in;

  assign full    = (count == 2'd2) || status.clearing;
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign take    = q_pop && q_valid;
  assign mag_in  = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
  assign q_sample = sample_q[rptr];
  assign q_mag    = mag_q[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q[wptr] <= sample_in;
      mag_q[wptr]    <= mag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) wptr <= ~wptr;
      if (take) rptr <= ~rptr;
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

endmodule

// ===== hw/rtl/lpl_div.sv =====
// lpl_div: restoring divider, one quotient bit per cycle
// depends on lpl_pkg; computes floor(num * 2^24 / den) for num < den
module lpl_div #(
  parameter int MAG_W = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [MAG_W-1:0]             num,
  input  logic [MAG_W-1:0]             den,
  output logic                         busy,
  output logic [lpl_pkg::QUOT_W-1:0]   quot
);

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] dvs;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;
  logic [4:0]       cnt;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
    end else if (busy) begin
      if (!diff[MAG_W]) begin
        rem  <= diff[MAG_W-1:0];
        quot <= {quot[lpl_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[MAG_W-1:0];
        quot <= {quot[lpl_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(lpl_pkg::QUOT_W - 1);
    end else if (busy) begin
      if (cnt == 5'd0) busy <= 1'b0;
      cnt <= cnt - 5'd1;
    end
  end

endmodule

// ===== hw/rtl/lpl_back.sv =====
// lpl_back: delay line, max tree walk, gain envelope and output register
// depends on lpl_pkg and lpl_div; takes items from lpl_front
module lpl_back #(
  parameter int LOOKAHEAD   = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lpl_pkg::REG_W-1:0]           threshold,
  input  logic [lpl_pkg::REG_W-1:0]           release_coeff,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  logic signed [SAMPLE_BITS-1:0]       q_sample,
  input  logic [SAMPLE_BITS-1:0]              q_mag,
  output lpl_pkg::back_status_t               status,
  output logic                                out_valid,
  input  logic                                pop,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic [lpl_pkg::GAIN_W-1:0]          gain_applied
);

  localparam int LA_W  = $clog2(LOOKAHEAD);
  localparam int TR_W  = LA_W + 1;
  localparam int MAG_W = SAMPLE_BITS;
  localparam int CMP_W = (MAG_W > lpl_pkg::REG_W) ? MAG_W : lpl_pkg::REG_W;
  localparam int GW    = lpl_pkg::GAIN_W;

  lpl_pkg::back_state_t state;
  lpl_pkg::back_state_t state_next;

  logic signed [SAMPLE_BITS-1:0] dl_mem [LOOKAHEAD];
  logic [MAG_W-1:0]              tr_mem [2*LOOKAHEAD];
  logic signed [SAMPLE_BITS-1:0] dl_q;
  logic [MAG_W-1:0]              tr_q;

  logic                          dl_we;
  logic [LA_W-1:0]               dl_wa;
  logic signed [SAMPLE_BITS-1:0] dl_wd;
  logic                          tr_we;
  logic [TR_W-1:0]               tr_wa;
  logic [MAG_W-1:0]              tr_wd;
  logic [TR_W-1:0]               tr_ra;

  logic [TR_W-1:0]               clr_cnt;
  logic [LA_W-1:0]               pos;
  logic [GW-1:0]                 env;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [MAG_W-1:0]              mag_r;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic                          gt_r;
  logic [lpl_pkg::REG_W+GW-1:0]  rel_prod;
  logic [GW-1:0]                 gain_r;
  logic [MAG_W+GW-1:0]           sprod;
  logic [TR_W-1:0]               node;
  logic [MAG_W-1:0]              cur;
  logic                          walking;

  logic [TR_W-1:0]               leaf;
  logic [TR_W-1:0]               parent;
  logic [MAG_W-1:0]              mx;
  logic                          gt;
  logic                          div_start;
  logic                          div_busy;
  logic [lpl_pkg::QUOT_W-1:0]    quot;
  logic [GW-1:0]                 target;
  logic [GW:0]                   released;
  logic [GW-1:0]                 gain;
  logic [MAG_W-1:0]              mag_d;
  logic [MAG_W-1:0]              mag_out;
  logic                          fire;

  assign leaf   = {1'b1, pos};
  assign parent = node >> 1;
  assign mx     = (cur > tr_q) ? cur : tr_q;
  assign gt     = CMP_W'(tr_q) > CMP_W'(threshold);
  assign target = gt_r ? GW'(quot) : lpl_pkg::UNITY_GAIN;
  assign released = (GW+1)'(env) + (GW+1)'(rel_prod >> lpl_pkg::GAIN_FRAC);
  assign mag_d  = delayed[SAMPLE_BITS-1] ? (~delayed + 1'b1) : delayed;
  assign mag_out = sprod[MAG_W+lpl_pkg::GAIN_FRAC-1:lpl_pkg::GAIN_FRAC];
  assign fire   = !out_valid || pop;

  always_comb begin
    gain = target;
    if ((GW+1)'(gain) > released) gain = GW'(released);
    if (gain > lpl_pkg::UNITY_GAIN) gain = lpl_pkg::UNITY_GAIN;
  end

  lpl_div #(.MAG_W(MAG_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (MAG_W'(CMP_W'(threshold))),
    .den   (tr_q),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    dl_q <= dl_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    tr_q <= tr_mem[tr_ra];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lpl_pkg::ST_CLEAR: if (clr_cnt == {TR_W{1'b1}}) state_next = lpl_pkg::ST_IDLE;
      lpl_pkg::ST_IDLE:  if (q_valid) state_next = lpl_pkg::ST_FETCH;
      lpl_pkg::ST_FETCH: state_next = lpl_pkg::ST_WORK;
      lpl_pkg::ST_WORK:  if (!walking && !div_busy) state_next = lpl_pkg::ST_GAIN;
      lpl_pkg::ST_GAIN:  state_next = lpl_pkg::ST_SCALE;
      lpl_pkg::ST_SCALE: state_next = lpl_pkg::ST_EMIT;
      lpl_pkg::ST_EMIT:  if (fire) state_next = lpl_pkg::ST_IDLE;
      default:           state_next = lpl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    dl_we     = 1'b0;
    dl_wa     = pos;
    dl_wd     = sample_r;
    tr_we     = 1'b0;
    tr_wa     = leaf;
    tr_wd     = mag_r;
    tr_ra     = TR_W'(1);
    div_start = 1'b0;
    unique case (state)
      lpl_pkg::ST_CLEAR: begin
        dl_we = 1'b1;
        dl_wa = clr_cnt[LA_W-1:0];
        dl_wd = '0;
        tr_we = 1'b1;
        tr_wa = clr_cnt;
        tr_wd = '0;
      end
      lpl_pkg::ST_IDLE: q_pop = q_valid;
      lpl_pkg::ST_FETCH: begin
        dl_we     = 1'b1;
        tr_we     = 1'b1;
        tr_ra     = leaf ^ TR_W'(1);
        div_start = gt;
      end
      lpl_pkg::ST_WORK: begin
        tr_we = walking;
        tr_wa = parent;
        tr_wd = mx;
        tr_ra = parent ^ TR_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpl_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      pos       <= '0;
      env       <= lpl_pkg::UNITY_GAIN;
      walking   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lpl_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == lpl_pkg::ST_FETCH) walking <= 1'b1;
      else if (state == lpl_pkg::ST_WORK && walking && parent == TR_W'(1)) walking <= 1'b0;
      if (state == lpl_pkg::ST_GAIN) env <= gain;
      if (state == lpl_pkg::ST_EMIT && fire) begin
        out_valid <= 1'b1;
        pos       <= pos + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lpl_pkg::ST_IDLE) begin
      sample_r <= q_sample;
      mag_r    <= q_mag;
    end
    if (state == lpl_pkg::ST_FETCH) begin
      delayed  <= dl_q;
      gt_r     <= gt;
      rel_prod <= release_coeff * (lpl_pkg::UNITY_GAIN - env);
      node     <= leaf;
      cur      <= mag_r;
    end
    if (state == lpl_pkg::ST_WORK && walking) begin
      node <= parent;
      cur  <= mx;
    end
    if (state == lpl_pkg::ST_GAIN) gain_r <= gain;
    if (state == lpl_pkg::ST_SCALE) sprod <= mag_d * gain_r;
    if (state == lpl_pkg::ST_EMIT && fire) begin
      sample_out   <= delayed[SAMPLE_BITS-1] ? -mag_out : mag_out;
      gain_applied <= gain_r;
    end
  end

  assign status.clearing = (state == lpl_pkg::ST_CLEAR);

endmodule

// ===== hw/rtl/lookahead_peak_limiter_top.sv =====
// lookahead_peak_limiter_top: limiter top level, config registers and wiring
// depends on lpl_pkg, lpl_front, lpl_div, lpl_back
//
//   channel  signals                                   beat
//   input    push, full, sample_in                     push && !full
//   result   empty, pop, sample_out, gain_applied      pop && !empty
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// one sample passes through idle, fetch, work, gain, scale and emit; work waits for
// the 24-step divider, started when the peak is above the threshold, and for the
// tree walk, which runs beside it
// after reset a clearing pass zeroes the delay line and the max tree and holds full high
// a two-entry input queue keeps taking samples while a result waits
// LOOKAHEAD must be a power of two
module lookahead_peak_limiter_top #(
  parameter int LOOKAHEAD   = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [SAMPLE_BITS-1:0]     sample_out,
  output logic [lpl_pkg::GAIN_W-1:0]        gain_applied,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpl_pkg::REG_W-1:0]         cfg_data
);

  logic [lpl_pkg::REG_W-1:0]     threshold;
  logic [lpl_pkg::REG_W-1:0]     release_coeff;
  lpl_pkg::back_status_t         status;
  logic                          q_valid;
  logic                          q_pop;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic [SAMPLE_BITS-1:0]        q_mag;
  logic                          out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= lpl_pkg::THRESHOLD_RST;
      release_coeff <= lpl_pkg::RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lpl_pkg::REG_THRESHOLD) threshold <= cfg_data;
      if (cfg_index == lpl_pkg::REG_RELEASE) release_coeff <= cfg_data;
    end
  end

  lpl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample_in (sample_in),
    .status    (status),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sample  (q_sample),
    .q_mag     (q_mag)
  );

  lpl_back #(.LOOKAHEAD(LOOKAHEAD), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .threshold     (threshold),
    .release_coeff (release_coeff),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_sample      (q_sample),
    .q_mag         (q_mag),
    .status        (status),
    .out_valid     (out_valid),
    .pop           (pop),
    .sample_out    (sample_out),
    .gain_applied  (gain_applied)
  );

`ifndef SYNTHESIS
  a_gain_unity: assert property (@(posedge clk) disable iff (rst)
    !empty |-> gain_applied <= lpl_pkg::UNITY_GAIN)
    else $error("gain above unity");

  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (!empty && gain_applied == '0) |-> sample_out == '0)
    else $error("nonzero output at zero gain");

  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> full && empty)
    else $error("beat possible during clearing pass");
`endif

endmodule

// ===== dv/tb_lookahead_peak_limiter_top.sv =====
// tb_lookahead_peak_limiter_top: self-checking bench for the lookahead peak limiter
// depends on lpl_pkg and lookahead_peak_limiter_top; a built-in limiter predictor
// checks every result beat, under several register settings and random idling
module tb_lookahead_peak_limiter_top;

  localparam int LOOKAHEAD   = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam logic [lpl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = 24'h800000;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    bit                            known;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic [lpl_pkg::GAIN_W-1:0]    gain_val;
  } stim_row_t;

  logic clk, rst;
  logic push, full, empty, pop;
  logic signed [SAMPLE_BITS-1:0] sample_in, sample_out;
  logic [lpl_pkg::GAIN_W-1:0] gain_applied;
  logic cfg_valid, cfg_ready;
  logic [lpl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lpl_pkg::REG_W-1:0] cfg_data;

  lookahead_peak_limiter_top #(.LOOKAHEAD(LOOKAHEAD), .SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample_in(sample_in),
    .empty(empty), .pop(pop), .sample_out(sample_out), .gain_applied(gain_applied),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // limiter state mirror
  logic [lpl_pkg::REG_W-1:0] thr_reg, rel_reg;
  logic signed [SAMPLE_BITS-1:0] delay_mem [LOOKAHEAD];
  longint unsigned max_tree [2*LOOKAHEAD];
  int unsigned wr_slot;
  longint unsigned env_gain;

  logic signed [SAMPLE_BITS-1:0] want_sample [$];
  logic [lpl_pkg::GAIN_W-1:0] want_gain [$];

  int errors, sent, received, cycles, idle_send, idle_recv, reduced_cnt;
  bit hold_req;
  int hold_left;
  stim_row_t rows [$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void limiter_reset();
    thr_reg = lpl_pkg::THRESHOLD_RST;
    rel_reg = lpl_pkg::RELEASE_RST;
    foreach (delay_mem[i]) delay_mem[i] = '0;
    foreach (max_tree[i]) max_tree[i] = 0;
    wr_slot = 0;
    env_gain = lpl_pkg::UNITY_GAIN;
  endfunction

  function automatic void limiter_step(input logic signed [SAMPLE_BITS-1:0] s,
                                       output logic signed [SAMPLE_BITS-1:0] o,
                                       output logic [lpl_pkg::GAIN_W-1:0] g);
    longint unsigned peak, target, released, gain, prod, a, b;
    longint d;
    int unsigned node;
    d = delay_mem[wr_slot];
    peak = max_tree[1];
    if (peak > thr_reg) target = (longint'(thr_reg) << 24) / peak;
    else target = lpl_pkg::UNITY_GAIN;
    released = env_gain + ((longint'(rel_reg) * (lpl_pkg::UNITY_GAIN - env_gain)) >> 24);
    gain = target < released ? target : released;
    if (gain > lpl_pkg::UNITY_GAIN) gain = lpl_pkg::UNITY_GAIN;
    env_gain = gain;
    prod = (mag(d) * gain) >> 24;
    o = SAMPLE_BITS'(d < 0 ? -longint'(prod) : longint'(prod));
    g = gain[lpl_pkg::GAIN_W-1:0];
    node = LOOKAHEAD + wr_slot;
    max_tree[node] = mag(s);
    while (node > 1) begin
      a = max_tree[node];
      b = max_tree[node ^ 1];
      max_tree[node >> 1] = a > b ? a : b;
      node = node >> 1;
    end
    delay_mem[wr_slot] = s;
    wr_slot = (wr_slot + 1) % LOOKAHEAD;
  endfunction

  task automatic send_sample(input stim_row_t r);
    logic signed [SAMPLE_BITS-1:0] o;
    logic [lpl_pkg::GAIN_W-1:0] g;
    if ($urandom_range(99) < idle_send) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_send);
    end
    push <= 1'b1;
    sample_in <= r.sample;
    do @(posedge clk); while (full);
    limiter_step(r.sample, o, g);
    if (g != lpl_pkg::UNITY_GAIN) reduced_cnt++;
    if (r.known) begin
      want_sample.push_back(r.out_val);
      want_gain.push_back(r.gain_val);
    end else begin
      want_sample.push_back(o);
      want_gain.push_back(g);
    end
    sent++;
  endtask

  task automatic write_reg(input logic [lpl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpl_pkg::REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lpl_pkg::REG_THRESHOLD) thr_reg = val;
    else if (idx == lpl_pkg::REG_RELEASE) rel_reg = val;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (want_sample.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    if ($urandom_range(7) == 0) return SAMPLE_BITS'($urandom);
    if ($urandom_range(31) == 0) return MOST_NEG;
    return SAMPLE_BITS'($urandom_range(131071) - 65536);
  endfunction

  // result side: check every beat, random stalls and one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (pop && !empty) begin
        if (want_sample.size() == 0) begin
          $display("%0t: unexpected beat sample_out=%0d gain_applied=%0d",
                   $time, sample_out, gain_applied);
          errors++;
        end else begin
          if (sample_out !== want_sample[0]) begin
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want_sample[0], sample_out);
            errors++;
          end
          if (gain_applied !== want_gain[0]) begin
            $display("%0t: gain_applied expected %0d actual %0d",
                     $time, want_gain[0], gain_applied);
            errors++;
          end
          void'(want_sample.pop_front());
          void'(want_gain.pop_front());
          received++;
        end
      end
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) hold_left--;
      pop <= (hold_left == 0) && ($urandom_range(99) >= idle_recv);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    errors = 0; sent = 0; received = 0; cycles = 0; reduced_cnt = 0;
    hold_req = 0; hold_left = 0;
    idle_send = 33; idle_recv = 78;
    rst = 1'b1; push = 1'b0; pop = 1'b0; sample_in = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    limiter_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // first beat after reset: zero output at unity gain; extremes go through the predictor
    rows = '{
      '{24'sh7FFFFF, 1, 0, lpl_pkg::UNITY_GAIN}, '{MOST_NEG, 0, 0, 0},
      '{24'sh000000, 0, 0, 0}, '{-24'sd1, 0, 0, 0},
      '{24'sh000001, 0, 0, 0}, '{24'sh555555, 0, 0, 0},
      '{24'shAAAAAA, 0, 0, 0}, '{24'sh7FFFF8, 0, 0, 0},
      '{24'sh7FFFF9, 0, 0, 0}, '{-24'sd8388600, 0, 0, 0},
      '{24'sh400000, 0, 0, 0}, '{24'shC00000, 0, 0, 0}
    };
    foreach (rows[i]) send_sample(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        drain();
        write_reg(lpl_pkg::REG_THRESHOLD, '0);
        write_reg(lpl_pkg::REG_RELEASE, '0);
        write_reg(REG_UNUSED, 24'hFFFFFF);
      end else if (ph == 2) begin
        drain();
        write_reg(lpl_pkg::REG_THRESHOLD, 24'd8388608);
        write_reg(lpl_pkg::REG_RELEASE, 24'hFFFFFF);
        idle_send = 78; idle_recv = 33;
      end else if (ph == 3) begin
        drain();
        write_reg(lpl_pkg::REG_THRESHOLD, 24'($urandom_range(8388607, 1048576)));
        write_reg(lpl_pkg::REG_RELEASE, 24'($urandom_range(65535)));
        idle_send = 0; idle_recv = 0;
        hold_req = 1'b1;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r.sample = rand_sample();
        r.known = 0;
        send_sample(r);
      end
    end
    push <= 1'b0;

    while (want_sample.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d samples sent, %0d results checked, %0d with reduced gain",
             sent, received, reduced_cnt);
    $display("four register settings incl. zero threshold and zero release");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lpl_pkg.sv
hw/rtl/lpl_front.sv
hw/rtl/lpl_div.sv
hw/rtl/lpl_back.sv
hw/rtl/lookahead_peak_limiter_top.sv
dv/tb_lookahead_peak_limiter_top.sv
